### sv/fsg_pkg.sv
// ----------------------------------------------------------------------------
// fsg_pkg
// shared types, codes and target tables for the falling sand grid step core
// ----------------------------------------------------------------------------
package fsg_pkg;

    localparam int CELL_COUNT = 64;
    localparam int CELL_STRIDE = 8;
    localparam int COORD_W = 3;
    localparam int IDX_W = 6;

    typedef logic [CELL_COUNT-1:0] grid_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COORD_W:0] coord_ext_t;
    typedef logic [1:0] dir_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    localparam dir_t DIR_DOWN_LEFT = 2'd0;
    localparam dir_t DIR_UP_RIGHT = 2'd1;
    localparam dir_t DIR_SIDE_PLUS = 2'd2;
    localparam dir_t DIR_SIDE_MINUS = 2'd3;

    // offsets in four-bit two's complement, added modulo 16
    localparam coord_ext_t OFS_P1 = 4'h1;
    localparam coord_ext_t OFS_Z = 4'h0;
    localparam coord_ext_t OFS_M1 = 4'hF;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic scan;
    } fsg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } fsg_status_t;

    function automatic coord_ext_t tgt_dx(dir_t dir, logic [1:0] k);
        coord_ext_t d;
        d = OFS_Z;
        case (dir)
            DIR_DOWN_LEFT:  d = (k == 2'd2) ? OFS_Z : OFS_P1;
            DIR_UP_RIGHT:   d = (k == 2'd2) ? OFS_Z : OFS_M1;
            DIR_SIDE_PLUS,
            DIR_SIDE_MINUS: d = (k == 2'd0) ? OFS_Z : ((k == 2'd1) ? OFS_P1 : OFS_M1);
            default:        d = OFS_Z;
        endcase
        return d;
    endfunction

    function automatic coord_ext_t tgt_dy(dir_t dir, logic [1:0] k);
        coord_ext_t d;
        d = OFS_Z;
        case (dir)
            DIR_DOWN_LEFT:  d = (k == 2'd1) ? OFS_Z : OFS_M1;
            DIR_UP_RIGHT:   d = (k == 2'd1) ? OFS_Z : OFS_P1;
            DIR_SIDE_PLUS:  d = OFS_P1;
            DIR_SIDE_MINUS: d = OFS_M1;
            default:        d = OFS_Z;
        endcase
        return d;
    endfunction

endpackage

### sv/fsg_if.sv
// ----------------------------------------------------------------------------
// fsg channel interfaces
// request and response word channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface fsg_req_if
    import fsg_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  req_type;
    grid_t grid_in;
    dir_t  direction;

    modport source (output valid, output req_type, output grid_in, output direction,
                    input ready);
    modport sink (input valid, input req_type, input grid_in, input direction,
                  output ready);
endinterface

interface fsg_rsp_if
    import fsg_pkg::*;
();
    logic  valid;
    logic  ready;
    grid_t grid_out;

    modport source (output valid, output grid_out, input ready);
    modport sink (input valid, input grid_out, output ready);
endinterface

### sv/fsg_ctrl.sv
// ----------------------------------------------------------------------------
// fsg_ctrl
// sequencer: takes a request word, runs the scan, presents the response word
// ----------------------------------------------------------------------------
module fsg_ctrl
    import fsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_type,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output fsg_cmd_t    cmd,
    input  fsg_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       req_fire;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_type == REQ_STEP)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a response word is pending");

    a_step_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_type == REQ_STEP) |=> (state_reg == ST_SCAN))
        else $error("step request did not start a scan");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && status.scan_last) |=> rsp_valid)
        else $error("last cell visited but no response word");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req_type == REQ_LOAD) |=> rsp_valid)
        else $error("load did not produce a response word");

endmodule

### sv/fsg_datapath.sv
// ----------------------------------------------------------------------------
// fsg_datapath
// grid register, scan counters and the per-cell move logic
// ----------------------------------------------------------------------------
module fsg_datapath
    import fsg_pkg::*;
#(
    parameter int GRID_SIZE = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fsg_cmd_t    cmd,
    input  grid_t       grid_in,
    input  dir_t        direction,
    output fsg_status_t status,
    output grid_t       grid_out
);

    localparam coord_t     G_LAST = COORD_W'(GRID_SIZE - 1);
    localparam coord_ext_t G_LIM  = (COORD_W + 1)'(GRID_SIZE);

    function automatic grid_t active_mask();
        grid_t m;
        m = '0;
        for (int x = 0; x < GRID_SIZE; x++)
        begin
            for (int y = 0; y < GRID_SIZE; y++)
            begin
                m[x * CELL_STRIDE + y] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam grid_t ACTIVE = active_mask();

    grid_t  grid_reg;
    grid_t  grid_next;
    coord_t a_reg;
    coord_t a_next;
    coord_t b_reg;
    coord_t b_next;
    dir_t   dir_reg;
    dir_t   dir_next;

    coord_t           cur_x;
    coord_t           cur_y;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] tgt_idx [3];
    logic             tgt_ok [3];
    coord_ext_t       tx;
    coord_ext_t       ty;
    logic             last_cell;

    // scan order per direction
    always_comb
    begin
        case (dir_reg)
            DIR_DOWN_LEFT:
            begin
                cur_x = G_LAST - a_reg;
                cur_y = b_reg;
            end
            DIR_UP_RIGHT:
            begin
                cur_x = a_reg;
                cur_y = G_LAST - b_reg;
            end
            DIR_SIDE_PLUS:
            begin
                cur_x = b_reg;
                cur_y = G_LAST - a_reg;
            end
            default:
            begin
                cur_x = b_reg;
                cur_y = a_reg;
            end
        endcase
    end

    assign cur_idx = {cur_x, cur_y};

    // off-grid targets wrap to 15 or land on GRID_SIZE, both fail the bound check
    always_comb
    begin
        tx = '0;
        ty = '0;
        for (int k = 0; k < 3; k++)
        begin
            tx = {1'b0, cur_x} + tgt_dx(dir_reg, 2'(k));
            ty = {1'b0, cur_y} + tgt_dy(dir_reg, 2'(k));
            tgt_idx[k] = {tx[COORD_W-1:0], ty[COORD_W-1:0]};
            tgt_ok[k]  = (tx < G_LIM) && (ty < G_LIM) && !grid_reg[tgt_idx[k]];
        end
    end

    assign last_cell        = (a_reg == G_LAST) && (b_reg == G_LAST);
    assign status.scan_last = last_cell;

    always_comb
    begin
        grid_next = grid_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        dir_next  = dir_reg;
        if (cmd.load)
        begin
            grid_next = grid_in & ACTIVE;
        end
        if (cmd.start)
        begin
            dir_next = direction;
            a_next   = '0;
            b_next   = '0;
        end
        if (cmd.scan)
        begin
            if (grid_reg[cur_idx])
            begin
                if (tgt_ok[0])
                begin
                    grid_next[cur_idx]    = 1'b0;
                    grid_next[tgt_idx[0]] = 1'b1;
                end
                else if (tgt_ok[1])
                begin
                    grid_next[cur_idx]    = 1'b0;
                    grid_next[tgt_idx[1]] = 1'b1;
                end
                else if (tgt_ok[2])
                begin
                    grid_next[cur_idx]    = 1'b0;
                    grid_next[tgt_idx[2]] = 1'b1;
                end
            end
            if (b_reg == G_LAST)
            begin
                b_next = '0;
                a_next = last_cell ? '0 : a_reg + 1'b1;
            end
            else
            begin
                b_next = b_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            dir_reg  <= DIR_DOWN_LEFT;
        end
        else
        begin
            grid_reg <= grid_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            dir_reg  <= dir_next;
        end
    end

    assign grid_out = grid_reg;

    a_grains_kept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |=> ($countones(grid_reg) == $countones($past(grid_reg))))
        else $error("scan created or lost a grain");

    a_outside_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_reg & ~ACTIVE) == '0)
        else $error("cell outside the grid is occupied");

    a_scan_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && last_cell) |=> (a_reg == '0 && b_reg == '0))
        else $error("scan position not back at zero after the last cell");

endmodule

### sv/falling_sand_grid_step_core.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_step_core
// occupancy grid with load and one-step in-place gravity scan
// ----------------------------------------------------------------------------
// load word: response valid the cycle after acceptance
// step word: scan visits one cell per cycle over all GRID_SIZE*GRID_SIZE cells
// step word: response valid once the scan has visited the last cell; a new
//   request is taken only after the response word has been taken
// reset: grid empty, scan position zero, controller idle and ready
module falling_sand_grid_step_core
    import fsg_pkg::*;
#(
    parameter int GRID_SIZE = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    fsg_req_if.sink   req_ch,
    fsg_rsp_if.source rsp_ch
);

    fsg_cmd_t    cmd;
    fsg_status_t status;
    logic        req_ready;
    logic        rsp_valid;
    grid_t       grid_out;

    fsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_type  (req_ch.req_type),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    fsg_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .grid_in   (req_ch.grid_in),
        .direction (req_ch.direction),
        .status    (status),
        .grid_out  (grid_out)
    );

    assign req_ch.ready    = req_ready;
    assign rsp_ch.valid    = rsp_valid;
    assign rsp_ch.grid_out = grid_out;

endmodule
